FILE: sv/wcfd_pkg.sv
// shared types and constants for the wheel count frame deframer
`timescale 1ns / 1ps

package wcfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 32;
  localparam int unsigned SumW   = 16;
  localparam int unsigned PosW   = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  // header byte value after reset
  localparam logic [ByteW-1:0] HeaderReset = 8'h58;

  // frame layout, byte positions within the 12-byte frame
  localparam logic [PosW-1:0] PosFirstHdr  = 4'd1;
  localparam logic [PosW-1:0] PosFirstData = 4'd2;
  localparam logic [PosW-1:0] PosRightCnt  = 4'd6;
  localparam logic [PosW-1:0] PosSumHigh   = 4'd10;

  // register index of header_byte
  localparam logic RegHeader = 1'b0;

  // frame status codes
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusCsumErr = 1'b1;

  typedef struct packed {
    logic signed [CountW-1:0] left_count;
    logic signed [CountW-1:0] right_count;
    logic                     frame_status;
  } frame_result_t;

endpackage

FILE: sv/wcfd_if.sv
// channel interfaces for received bytes and decoded frames
`timescale 1ns / 1ps

interface wcfd_in_if;
  logic                           valid;
  logic                           ready;
  logic [wcfd_pkg::ByteW-1:0]     rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wcfd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wcfd_pkg::CountW-1:0] left_count;
  logic signed [wcfd_pkg::CountW-1:0] right_count;
  logic                               frame_status;

  modport source (output valid, output left_count, output right_count,
                  output frame_status, input ready);
  modport sink (input valid, input left_count, input right_count,
                input frame_status, output ready);
endinterface

FILE: sv/wheel_count_frame_deframer.sv
// Wheel count frame deframer top level.
// Received serial bytes enter on in_chan, one byte per transaction. The block
// hunts for two consecutive header bytes, then collects the rest of a 12-byte
// frame: two big-endian 32-bit wheel counts and a big-endian 16-bit checksum
// that must equal the 16-bit sum of the first ten frame bytes.
// At the last byte of every frame one transaction leaves on out_chan with both
// counts and frame_status (0 ok, 1 checksum error, counts then zero).
// The header value is set through the APB port at address 0 (reset 0x58).
// Throughput: one byte per cycle while the result side has room. A byte is
// captured in an input register, the state machine takes it from there, and
// a frame result is registered in the output register that drives out_chan.
// When the receiver stalls, a result waits in the output register and a
// second one in a skid slot; in_chan.ready drops only while both are full.
// Reset (rst_n low, synchronous) returns the hunt to idle, clears the sums
// and counts, empties the input and output registers and restores the header.
`timescale 1ns / 1ps

module wheel_count_frame_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  wcfd_in_if.sink                       in_chan,
  wcfd_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wcfd_pkg::AddrW-1:0]    paddr,
  input  logic [wcfd_pkg::DataW-1:0]    pwdata,
  output logic [wcfd_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import wcfd_pkg::*;

  logic                in_valid_r, in_valid_nxt;
  logic [ByteW-1:0]    in_byte_r, in_byte_nxt;
  logic [ByteW-1:0]    header_r, header_nxt;
  logic                proc_fire;
  logic                buf_full;
  logic                res_valid;
  frame_result_t       res_data;
  logic                in_take;
  logic                cfg_write;

  // configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    header_nxt = header_r;
    if (cfg_write && paddr[AddrW-1] == RegHeader) begin
      header_nxt = pwdata[ByteW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[AddrW-1] == RegHeader) begin
      prdata = {{(DataW-ByteW){1'b0}}, header_r};
    end
  end

  // input register, held while the result side is full
  assign proc_fire     = in_valid_r & ~buf_full;
  assign in_chan.ready = ~in_valid_r | proc_fire;
  assign in_take       = in_chan.valid & in_chan.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_chan.rx_byte;
    end else if (proc_fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      header_r   <= HeaderReset;
    end else begin
      in_valid_r <= in_valid_nxt;
      header_r   <= header_nxt;
    end
    in_byte_r <= in_byte_nxt;
  end

  wcfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_fire   (proc_fire),
    .byte_in     (in_byte_r),
    .header_byte (header_r),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  wcfd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .full      (buf_full),
    .out_chan  (out_chan)
  );

endmodule

FILE: sv/wcfd_parser.sv
// frame hunt and collect state machine, one byte per cycle with byte_fire high
`timescale 1ns / 1ps

module wcfd_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_fire,
  input  logic [wcfd_pkg::ByteW-1:0]    byte_in,
  input  logic [wcfd_pkg::ByteW-1:0]    header_byte,
  output logic                          res_valid,
  output wcfd_pkg::frame_result_t       res_data
);
  import wcfd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ONE,
    PH_COLLECT
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [PosW-1:0]     pos_r, pos_nxt;
  logic [SumW-1:0]     sum_r, sum_nxt;
  logic [CountW-1:0]   left_r, left_nxt;
  logic [CountW-1:0]   right_r, right_nxt;
  logic [ByteW-1:0]    sum_hi_r, sum_hi_nxt;

  logic [SumW-1:0]     sum_add;
  logic [SumW-1:0]     rx_sum;
  logic                sum_ok;

  assign sum_add = sum_r + {{(SumW-ByteW){1'b0}}, byte_in};
  assign rx_sum  = {sum_hi_r, byte_in};
  assign sum_ok  = (rx_sum == sum_r);

  // next state for one accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    sum_hi_nxt = sum_hi_r;
    res_valid  = 1'b0;
    res_data.left_count   = left_r;
    res_data.right_count  = right_r;
    res_data.frame_status = StatusOk;
    if (sum_ok == 1'b0) begin
      res_data.left_count   = '0;
      res_data.right_count  = '0;
      res_data.frame_status = StatusCsumErr;
    end
    if (byte_fire) begin
      case (phase_r)
        PH_ONE: begin
          if (byte_in == header_byte) begin
            phase_nxt = PH_COLLECT;
            pos_nxt   = PosFirstData;
            sum_nxt   = sum_add;
          end else begin
            phase_nxt  = PH_IDLE;
            pos_nxt    = '0;
            sum_nxt    = '0;
            left_nxt   = '0;
            right_nxt  = '0;
            sum_hi_nxt = '0;
          end
        end
        PH_COLLECT: begin
          if (pos_r < PosRightCnt) begin
            left_nxt = {left_r[CountW-ByteW-1:0], byte_in};
            sum_nxt  = sum_add;
            pos_nxt  = pos_r + 1'b1;
          end else if (pos_r < PosSumHigh) begin
            right_nxt = {right_r[CountW-ByteW-1:0], byte_in};
            sum_nxt   = sum_add;
            pos_nxt   = pos_r + 1'b1;
          end else if (pos_r == PosSumHigh) begin
            sum_hi_nxt = byte_in;
            pos_nxt    = pos_r + 1'b1;
          end else begin
            // final checksum byte: emit and go back to hunting
            res_valid  = 1'b1;
            phase_nxt  = PH_IDLE;
            pos_nxt    = '0;
            sum_nxt    = '0;
            left_nxt   = '0;
            right_nxt  = '0;
            sum_hi_nxt = '0;
          end
        end
        default: begin
          phase_nxt  = PH_IDLE;
          pos_nxt    = '0;
          sum_nxt    = '0;
          left_nxt   = '0;
          right_nxt  = '0;
          sum_hi_nxt = '0;
          if (byte_in == header_byte) begin
            phase_nxt = PH_ONE;
            pos_nxt   = PosFirstHdr;
            sum_nxt   = {{(SumW-ByteW){1'b0}}, byte_in};
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      sum_r    <= '0;
      left_r   <= '0;
      right_r  <= '0;
      sum_hi_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      sum_hi_r <= sum_hi_nxt;
    end
  end

endmodule

FILE: sv/wcfd_outbuf.sv
// result register with a skid slot in front of the output channel
`timescale 1ns / 1ps

module wcfd_outbuf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  wcfd_pkg::frame_result_t push_data,
  output logic                    full,
  wcfd_out_if.source              out_chan
);
  import wcfd_pkg::*;

  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  frame_result_t out_data_r, out_data_nxt;
  frame_result_t skid_data_r, skid_data_nxt;
  logic          take;

  assign take = out_valid_r & out_chan.ready;
  assign full = skid_valid_r;

  // move results between skid slot and output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (take) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.left_count   = out_data_r.left_count;
  assign out_chan.right_count  = out_data_r.right_count;
  assign out_chan.frame_status = out_data_r.frame_status;

endmodule

FILE: sim/tb_wheel_count_frame_deframer.sv
// self-checking testbench for the wheel count frame deframer
`timescale 1ns / 1ps

module tb_wheel_count_frame_deframer;
  import wcfd_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned IdleWait    = 6;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseItems  = 295;
  localparam int unsigned NumPhases   = 5;
  localparam int unsigned FrameBytes  = 12;
  localparam logic [PosW-1:0] PosLast = 4'd11;

  localparam logic [AddrW-1:0] HeaderAddr = {RegHeader, 2'b00};
  localparam logic [AddrW-1:0] SpareAddr  = {~RegHeader, 2'b00};

  typedef enum logic [1:0] {HuntIdle, HuntOne, HuntCollect} hunt_phase_t;
  typedef enum int unsigned {SinkAlways, SinkRandom, SinkPattern, SinkSparse} sink_mode_t;

  // predictor of the deframer plus the queue of frames still to come out
  class frame_scoreboard;
    logic [ByteW-1:0]  header;
    hunt_phase_t       phase;
    logic [PosW-1:0]   pos;
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] left_acc;
    logic [CountW-1:0] right_acc;
    logic [ByteW-1:0]  sum_high;
    frame_result_t     pending_frames[$];
    int unsigned       mismatches;
    int unsigned       frames_good;
    int unsigned       frames_bad;

    function void go_idle();
      phase     = HuntIdle;
      pos       = '0;
      sum       = '0;
      left_acc  = '0;
      right_acc = '0;
      sum_high  = '0;
    endfunction

    function void reset_state();
      header = HeaderReset;
      go_idle();
    endfunction

    function void write_reg(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
      if (addr[AddrW-1:2] == RegHeader) header = data[ByteW-1:0];
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    // one accepted byte through the hunt and collect logic
    function void note_byte(logic [ByteW-1:0] b);
      frame_result_t fr;
      logic [SumW-1:0] received;
      case (phase)
        HuntOne: begin
          if (b == header) begin
            phase = HuntCollect;
            pos   = PosFirstData;
            sum   = sum + {8'h00, b};
          end else begin
            go_idle();
          end
        end
        HuntCollect: begin
          if (pos < PosRightCnt) begin
            left_acc = {left_acc[CountW-9:0], b};
            sum      = sum + {8'h00, b};
            pos      = pos + 1'b1;
          end else if (pos < PosSumHigh) begin
            right_acc = {right_acc[CountW-9:0], b};
            sum       = sum + {8'h00, b};
            pos       = pos + 1'b1;
          end else if (pos == PosSumHigh) begin
            sum_high = b;
            pos      = PosLast;
          end else begin
            received = {sum_high, b};
            if (received == sum) begin
              fr.left_count   = left_acc;
              fr.right_count  = right_acc;
              fr.frame_status = StatusOk;
            end else begin
              fr.left_count   = '0;
              fr.right_count  = '0;
              fr.frame_status = StatusCsumErr;
            end
            pending_frames.push_back(fr);
            go_idle();
          end
        end
        default: begin
          go_idle();
          if (b == header) begin
            phase = HuntOne;
            pos   = PosFirstHdr;
            sum   = {8'h00, b};
          end
        end
      endcase
    endfunction

    // compare one decoded frame against the oldest prediction
    function void check_frame(frame_result_t got);
      frame_result_t exp;
      if (pending_frames.size() == 0) begin
        report($sformatf("unexpected frame left=%0d right=%0d status=%0b",
                         got.left_count, got.right_count, got.frame_status));
        return;
      end
      exp = pending_frames.pop_front();
      if (got.left_count !== exp.left_count || got.right_count !== exp.right_count ||
          got.frame_status !== exp.frame_status) begin
        report($sformatf("frame exp left=%0d right=%0d status=%0b, got left=%0d right=%0d status=%0b",
                         exp.left_count, exp.right_count, exp.frame_status,
                         got.left_count, got.right_count, got.frame_status));
      end else if (exp.frame_status == StatusOk) begin
        frames_good++;
      end else begin
        frames_bad++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  wcfd_in_if  in_chan ();
  wcfd_out_if out_chan ();

  wheel_count_frame_deframer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  frame_scoreboard sb = new();

  logic [ByteW-1:0] frame_buf [FrameBytes];
  logic [ByteW-1:0] tx_q[$];
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  int unsigned holds_done;
  int unsigned headers_used;
  sink_mode_t  sink_mode;
  bit          hold_off_req;

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d frames outstanding", cycle_count,
               sb.pending_frames.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result receiver: stall pattern, plus a long hold-off on request
  initial begin : result_sink
    int unsigned tick;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end else begin
        tick++;
        case (sink_mode)
          SinkAlways:  out_chan.ready <= 1'b1;
          SinkRandom:  out_chan.ready <= 1'($urandom_range(1, 0));
          SinkPattern: out_chan.ready <= ((tick % 7) >= 3);
          default:     out_chan.ready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    frame_result_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.left_count   = out_chan.left_count;
      got.right_count  = out_chan.right_count;
      got.frame_status = out_chan.frame_status;
      sb.check_frame(got);
    end
  end

  // apb write: setup then access, register takes the value at the access edge
  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // read the header register back and compare with the predicted value
  task automatic check_header_reg();
    logic [DataW-1:0] data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= HeaderAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (data[ByteW-1:0] !== sb.header)
      sb.report($sformatf("header register exp %02h got %02h", sb.header, data[ByteW-1:0]));
    @(posedge clk);
  endtask

  // one byte transaction, with burst and gap shaping on the sender side
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid   <= 1'b1;
    in_chan.rx_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_all();
    while (tx_q.size() != 0) send_byte(tx_q.pop_front());
  endtask

  // stop offering, wait for every predicted frame, then let the pipeline settle
  task automatic drain();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
  endtask

  // fill frame_buf with a complete frame, optionally with a corrupted checksum
  function automatic void build_frame(input logic [ByteW-1:0] hdr, input logic [CountW-1:0] l,
                                      input logic [CountW-1:0] r, input bit bad);
    logic [SumW-1:0] csum;
    frame_buf[0] = hdr;
    frame_buf[1] = hdr;
    for (int i = 0; i < 4; i++) begin
      frame_buf[2 + i] = l[CountW-1-8*i -: 8];
      frame_buf[6 + i] = r[CountW-1-8*i -: 8];
    end
    csum = '0;
    for (int i = 0; i < 10; i++) csum = csum + {8'h00, frame_buf[i]};
    if (bad) csum = csum ^ 16'($urandom_range(16'hFFFF, 1));
    frame_buf[10] = csum[15:8];
    frame_buf[11] = csum[7:0];
  endfunction

  function automatic void queue_slice(input int unsigned lo, input int unsigned hi);
    for (int unsigned i = lo; i < hi; i++) tx_q.push_back(frame_buf[i]);
  endfunction

  function automatic logic [CountW-1:0] pick_count(input logic [ByteW-1:0] hdr);
    case ($urandom_range(7, 0))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return {4{hdr}};
      default: return $urandom();
    endcase
  endfunction

  // mostly well-formed frames, some truncated, broken headers and line noise
  function automatic void queue_piece(input logic [ByteW-1:0] hdr);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 72) begin
      build_frame(hdr, pick_count(hdr), pick_count(hdr), $urandom_range(4, 0) == 0);
      queue_slice(0, FrameBytes);
    end else if (r < 80) begin
      build_frame(hdr, pick_count(hdr), pick_count(hdr), 1'b0);
      queue_slice(0, $urandom_range(FrameBytes - 1, 3));
    end else if (r < 88) begin
      tx_q.push_back(hdr);
      tx_q.push_back(hdr ^ 8'($urandom_range(255, 1)));
    end else begin
      repeat ($urandom_range(6, 1)) tx_q.push_back(8'($urandom_range(255, 0)));
    end
  endfunction

  // stimulus
  initial begin : stimulus
    logic [ByteW-1:0] hdr;
    int unsigned target;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.rx_byte = '0;
    out_chan.ready  = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    hold_off_req    = 1'b0;
    sink_mode       = SinkRandom;
    gap_max         = 4;
    sb.reset_state();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_header_reg();
    headers_used = 1;

    // extreme counts, split by a header change while the frame is in progress
    build_frame(HeaderReset, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    queue_slice(0, 3);
    send_all();
    drain();
    apb_write(HeaderAddr, 32'hFFFF_FFFF);
    check_header_reg();
    // write to an unmapped index must not disturb the header
    apb_write(SpareAddr, 32'h0000_00A5);
    check_header_reg();
    headers_used++;
    queue_slice(3, FrameBytes);
    // broken header, then a bad checksum frame whose left count holds header bytes
    tx_q.push_back(8'hFF);
    tx_q.push_back(8'h00);
    build_frame(8'hFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    queue_slice(0, FrameBytes);
    send_all();
    drain();

    // random phases, one header setting each
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin hdr = 8'h00; sink_mode = SinkRandom; gap_max = 6; end
        1: begin hdr = 8'($urandom_range(255, 0)); sink_mode = SinkPattern; gap_max = 3; end
        2: begin hdr = HeaderReset; sink_mode = SinkAlways; gap_max = 0; end
        3: begin hdr = 8'hFF; sink_mode = SinkSparse; gap_max = 10; end
        default: begin hdr = 8'($urandom_range(255, 0)); sink_mode = SinkRandom; gap_max = 0; end
      endcase
      apb_write(HeaderAddr, {24'($urandom()), hdr});
      check_header_reg();
      headers_used++;
      if (p == 2) hold_off_req = 1'b1;
      target = bytes_sent + PhaseItems;
      while (bytes_sent < target) begin
        queue_piece(hdr);
        send_all();
      end
      drain();
    end

    $display("covered %0d bytes under %0d header settings, %0d long receiver hold-offs",
             bytes_sent, headers_used, holds_done);
    $display("frames matched: %0d with good checksum, %0d with checksum error",
             sb.frames_good, sb.frames_bad);
    if (sb.mismatches == 0 && sb.pending_frames.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d frames never seen", sb.mismatches,
               sb.pending_frames.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/wcfd_pkg.sv
sv/wcfd_if.sv
sv/wcfd_parser.sv
sv/wcfd_outbuf.sv
sv/wheel_count_frame_deframer.sv
sim/tb_wheel_count_frame_deframer.sv
